FILE: rtl/core/mm_pkg.sv
// Shared types and constants for the matrix multiply core.
package mm_pkg;

    localparam int unsigned MAX_DIM    = 8;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned IDX_W      = $clog2(MAX_DIM);
    localparam int unsigned DIM_W      = 4;
    localparam int unsigned ADDR_W     = 2 * IDX_W;
    localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_WRITE_A = 2'd0,
        REQ_WRITE_B = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    // Register indexes (word address on the APB port)
    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Saturate a dimension register to MAX_DIM
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
        return r;
    endfunction

endpackage

FILE: rtl/core/matrix_multiply_core.sv
// Matrix multiply core: element stores, MAC sequencer and APB dimension registers.
//
// Usage:
//   Input stream (s_*): one beat per request. tuser holds the request kind:
//   write an A element, write a B element, or compute C = A * B. tdata holds
//   row, col and the element value (ignored on compute).
//   Output stream (m_*): one beat per C element in row-major order; tlast
//   marks the final element of a compute run. tdata holds row, col, product.
//   APB port: rows_a at 0x0, inner_dim at 0x4, cols_b at 0x8 (4 bits each,
//   values above 8 are used as 8). Write only while the core is idle.
// Timing:
//   An element write leaves the core idle; a new beat can follow right after.
//   A compute request is accepted while idle; for each C element the sequencer
//   then steps along the inner dimension (straight to the drain when inner_dim
//   is zero): one A and one B memory read per cycle feed the single 32x32
//   multiply-accumulate; it drains before the output register is loaded.
//   s_tready stays low while a compute run is in progress.
// Reset: dimension registers return to 8, the output register empties; the
//   element stores keep no reset value and must be written before use.
// Stall: a waiting result sits in the output register; the sequencer holds
//   until it is taken. Products wrap modulo 2^32.
module matrix_multiply_core (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product[37:6], zero
    output logic        m_tlast,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = mm_pkg::IDX_W;
    localparam int unsigned DW = mm_pkg::DIM_W;
    localparam int unsigned XW = mm_pkg::DATA_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [DW-1:0]    rows_a_reg, inner_dim_reg, cols_b_reg;
    mm_pkg::reg_idx_t cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = mm_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mm_pkg::DIM_RESET;
            inner_dim_reg <= mm_pkg::DIM_RESET;
            cols_b_reg    <= mm_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                mm_pkg::REG_ROWS_A:    rows_a_reg    <= pwdata[DW-1:0];
                mm_pkg::REG_INNER_DIM: inner_dim_reg <= pwdata[DW-1:0];
                mm_pkg::REG_COLS_B:    cols_b_reg    <= pwdata[DW-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            mm_pkg::REG_ROWS_A:    prdata = {{(32-DW){1'b0}}, rows_a_reg};
            mm_pkg::REG_INNER_DIM: prdata = {{(32-DW){1'b0}}, inner_dim_reg};
            mm_pkg::REG_COLS_B:    prdata = {{(32-DW){1'b0}}, cols_b_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // effective dimensions
    logic [DW-1:0] dim_n, dim_p, dim_m;
    assign dim_n = mm_pkg::dim_clamp(rows_a_reg);
    assign dim_p = mm_pkg::dim_clamp(inner_dim_reg);
    assign dim_m = mm_pkg::dim_clamp(cols_b_reg);

    // ---------------- input decode ----------------
    logic [IW-1:0] in_row, in_col;
    logic [XW-1:0] in_value;
    mm_pkg::req_t  in_req;
    logic          in_accept;

    assign in_row    = s_tdata[IW-1:0];
    assign in_col    = s_tdata[2*IW-1:IW];
    assign in_value  = s_tdata[2*IW+XW-1:2*IW];
    assign in_req    = mm_pkg::req_t'(s_tuser);
    assign in_accept = s_tvalid & s_tready;

    // ---------------- sequencer ----------------
    state_t        state_reg, state_next;
    logic [IW-1:0] r_reg, c_reg, i_reg;
    logic          out_free, pipe_empty, last_elem, last_inner;
    logic          rd_valid_reg, prod_valid_reg;
    logic          start_run;

    assign s_tready   = (state_reg == S_IDLE);
    assign out_free   = ~m_tvalid | m_tready;
    assign pipe_empty = ~rd_valid_reg & ~prod_valid_reg;
    assign last_elem  = ({1'b0, r_reg} == dim_n - DW'(1)) &&
                        ({1'b0, c_reg} == dim_m - DW'(1));
    assign last_inner = ({1'b0, i_reg} == dim_p - DW'(1));
    assign start_run  = in_accept && (in_req == mm_pkg::REQ_COMPUTE) &&
                        (dim_n != '0) && (dim_m != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start_run)
                    state_next = (dim_p == '0) ? S_WAIT : S_ISSUE;
            S_ISSUE:
                if (last_inner)
                    state_next = S_WAIT;
            S_WAIT:
                if (pipe_empty)
                    state_next = S_EMIT;
            S_EMIT:
                if (out_free)
                begin
                    if (last_elem)
                        state_next = S_IDLE;
                    else
                        state_next = (dim_p == '0) ? S_WAIT : S_ISSUE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    r_reg <= '0;
                    c_reg <= '0;
                    i_reg <= '0;
                end
                S_ISSUE:
                    i_reg <= last_inner ? '0 : i_reg + IW'(1);
                S_EMIT:
                    if (out_free && !last_elem)
                    begin
                        if ({1'b0, c_reg} == dim_m - DW'(1))
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + IW'(1);
                        end
                        else
                            c_reg <= c_reg + IW'(1);
                    end
                default:
                    ;
            endcase
        end
    end

    // ---------------- element stores ----------------
    logic [XW-1:0] a_mem [mm_pkg::DEPTH];
    logic [XW-1:0] b_mem [mm_pkg::DEPTH];
    logic [XW-1:0] a_rd_reg, b_rd_reg;
    logic [mm_pkg::ADDR_W-1:0] wr_addr;

    assign wr_addr = {in_row, in_col};

    always_ff @(posedge clk)
    begin
        if (in_accept && (in_req == mm_pkg::REQ_WRITE_A))
            a_mem[wr_addr] <= in_value;
        if (in_accept && (in_req == mm_pkg::REQ_WRITE_B))
            b_mem[wr_addr] <= in_value;
    end

    // A is read along row r, B down column c
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ISSUE)
        begin
            a_rd_reg <= a_mem[{r_reg, i_reg}];
            b_rd_reg <= b_mem[{i_reg, c_reg}];
        end
    end

    // ---------------- multiply-accumulate ----------------
    logic [XW-1:0] prod_reg, acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= (state_reg == S_ISSUE);
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= XW'(a_rd_reg * b_rd_reg);
        if (state_reg == S_IDLE || (state_reg == S_EMIT && out_free))
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + prod_reg;
    end

    // ---------------- output register ----------------
    logic          out_valid_reg, out_last_reg;
    logic [IW-1:0] out_row_reg, out_col_reg;
    logic [XW-1:0] out_prod_reg;
    logic          out_load;

    assign out_load = (state_reg == S_EMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= r_reg;
            out_col_reg  <= c_reg;
            out_prod_reg <= acc_reg;
            out_last_reg <= last_elem;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(40-2*IW-XW){1'b0}}, out_prod_reg, out_col_reg, out_row_reg};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for matrix_multiply_core: element loads, C = A * B, APB dimensions.
`timescale 1ns / 100ps

module tb;

    localparam int TOTAL_BEATS = 260;
    localparam int DRAIN_TAIL  = 40;

    // one emitted C element as predicted
    typedef struct {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [31:0] product;
        logic        last;
    } c_elem_t;

    // one row of the directed table: a register write or an input beat
    typedef struct {
        bit               is_cfg;
        mm_pkg::reg_idx_t idx;
        logic [3:0]       dim;
        mm_pkg::req_t     req;
        logic [2:0]       row;
        logic [2:0]       col;
        logic [31:0]      value;
        bit               chk;     // product typed in below overrides the prediction
        logic [31:0]      want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // row[2:0], col[5:3], value[37:6], zero fill
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_row[2:0], out_col[5:3], product[37:6], zero fill
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    matrix_multiply_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the element stores and dimension registers
    logic [31:0] a_elem [0:mm_pkg::DEPTH-1];
    logic [31:0] b_elem [0:mm_pkg::DEPTH-1];
    logic [3:0]  rows_q;
    logic [3:0]  inner_q;
    logic [3:0]  cols_q;

    c_elem_t  c_pending [$];
    dir_row_t dir_tab [0:24];

    int errors     = 0;
    int n_beats    = 0;
    int n_computes = 0;
    int n_elems    = 0;
    int rdy_left   = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    // updates the shadow stores and works out the C elements caused by one accepted beat
    task automatic predict_beat(input mm_pkg::req_t req, input logic [2:0] row,
                                input logic [2:0] col, input logic [31:0] value,
                                input bit chk, input logic [31:0] want);
        int n;
        int p;
        int m;
        int cnt;
        logic [31:0] acc;
        c_elem_t e;
        case (req)
            mm_pkg::REQ_WRITE_A: a_elem[{row, col}] = value;
            mm_pkg::REQ_WRITE_B: b_elem[{row, col}] = value;
            mm_pkg::REQ_COMPUTE:
            begin
                n = (rows_q > 4'd8) ? 8 : int'(rows_q);
                p = (inner_q > 4'd8) ? 8 : int'(inner_q);
                m = (cols_q > 4'd8) ? 8 : int'(cols_q);
                cnt = 0;
                for (int r = 0; r < n; r++)
                begin
                    for (int c = 0; c < m; c++)
                    begin
                        acc = '0;
                        for (int i = 0; i < p; i++)
                            acc += a_elem[r * 8 + i] * b_elem[i * 8 + c];
                        cnt++;
                        e.out_row = 3'(r);
                        e.out_col = 3'(c);
                        e.product = chk ? want : acc;
                        e.last    = (cnt == n * m);
                        c_pending.push_back(e);
                    end
                end
            end
            default: ;  // unknown request: nothing happens
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8)
            return 0;
        else if (r < 13)
            return $urandom_range(1, 3);
        else if (r < 15)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // mostly small dimensions, now and then zero, full size or saturating
    function automatic logic [3:0] pick_dim();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 4'($urandom_range(1, 3));
            6: return 4'd0;
            7: return 4'd8;
            8: return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic dir_row_t cfg_row(input mm_pkg::reg_idx_t idx, input logic [3:0] dim);
        dir_row_t d;
        d = '{1'b1, idx, dim, mm_pkg::REQ_NONE, 3'd0, 3'd0, 32'd0, 1'b0, 32'd0};
        return d;
    endfunction

    function automatic dir_row_t beat_row(input mm_pkg::req_t req, input logic [2:0] row,
                                          input logic [2:0] col, input logic [31:0] value,
                                          input bit chk, input logic [31:0] want);
        dir_row_t d;
        d = '{1'b0, mm_pkg::REG_UNUSED, 4'd0, req, row, col, value, chk, want};
        return d;
    endfunction

    // drive one beat at the falling edge, hold until taken, then idle for a random gap that may be empty
    task automatic send_beat(input mm_pkg::req_t req, input logic [2:0] row,
                             input logic [2:0] col, input logic [31:0] value,
                             input bit chk, input logic [31:0] want);
        int g;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {2'b00, value, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(req, row, col, value, chk, want);
        n_beats++;
        if (req == mm_pkg::REQ_COMPUTE)
            n_computes++;
        g = pick_gap();
        repeat (g)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // stop sending and wait until every predicted element has come out
    task automatic wait_idle(input int tail);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (c_pending.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input mm_pkg::reg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write a register, then read it back unless it is the unused index
    task automatic cfg_write(input mm_pkg::reg_idx_t idx, input logic [3:0] dim);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, {28'd0, dim}, rd);
        case (idx)
            mm_pkg::REG_ROWS_A:    rows_q  = dim;
            mm_pkg::REG_INNER_DIM: inner_q = dim;
            mm_pkg::REG_COLS_B:    cols_q  = dim;
            default: ;
        endcase
        if (idx != mm_pkg::REG_UNUSED)
        begin
            apb_xfer(1'b0, idx, 32'd0, rd);
            if (rd !== {28'd0, dim})
                report_mismatch("register readback", rd, {28'd0, dim});
        end
    endtask

    // receiver: ready stretches and stalls of random length
    always @(negedge clk)
    begin
        int r;
        if (rdy_left == 0)
        begin
            r = $urandom_range(0, 15);
            if (r < 6)
            begin
                m_tready = 1'b1;
                rdy_left = $urandom_range(1, 8);
            end
            else if (r < 10)
            begin
                m_tready = 1'b1;
                rdy_left = $urandom_range(20, 60);
            end
            else if (r < 14)
            begin
                m_tready = 1'b0;
                rdy_left = $urandom_range(1, 3);
            end
            else
            begin
                m_tready = 1'b0;
                rdy_left = $urandom_range(10, 40);
            end
        end
        else
            rdy_left--;
    end

    // result checker
    always @(posedge clk)
    begin
        c_elem_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_elems++;
            if (c_pending.size() == 0)
                report_mismatch("unexpected C element", m_tdata[31:0], 32'd0);
            else
            begin
                e = c_pending.pop_front();
                if (m_tdata[2:0] !== e.out_row)
                    report_mismatch("out_row", 32'(m_tdata[2:0]), 32'(e.out_row));
                if (m_tdata[5:3] !== e.out_col)
                    report_mismatch("out_col", 32'(m_tdata[5:3]), 32'(e.out_col));
                if (m_tdata[37:6] !== e.product)
                    report_mismatch("product", m_tdata[37:6], e.product);
                if (m_tlast !== e.last)
                    report_mismatch("last", 32'(m_tlast), 32'(e.last));
            end
        end
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d C elements outstanding", c_pending.size());
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [31:0] rd;
        int nw;
        int r;
        mm_pkg::req_t rq;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = mm_pkg::REQ_NONE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rows_q   = mm_pkg::DIM_RESET;
        inner_q  = mm_pkg::DIM_RESET;
        cols_q   = mm_pkg::DIM_RESET;
        for (int i = 0; i < mm_pkg::DEPTH; i++)
        begin
            a_elem[i] = '0;
            b_elem[i] = '0;
        end

        dir_tab = '{
            cfg_row(mm_pkg::REG_ROWS_A, 4'd1),
            cfg_row(mm_pkg::REG_INNER_DIM, 4'd1),
            cfg_row(mm_pkg::REG_COLS_B, 4'd1),
            // largest positive squared wraps to 1
            beat_row(mm_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1'b1, 32'h0000_0001),
            // most negative times -1 stays most negative
            beat_row(mm_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'hffff_ffff, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b1, 32'h8000_0000),
            // most negative squared wraps to 0
            beat_row(mm_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b1, 32'h0000_0000),
            beat_row(mm_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'hffff_fffd, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'h0000_0005, 1'b0, 32'd0),
            // unknown request must not touch the store
            beat_row(mm_pkg::REQ_NONE, 3'd0, 3'd0, 32'd0, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b1, 32'hffff_fff1),
            // zero rows, then zero columns: no elements at all
            cfg_row(mm_pkg::REG_ROWS_A, 4'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b0, 32'd0),
            cfg_row(mm_pkg::REG_ROWS_A, 4'd1),
            cfg_row(mm_pkg::REG_COLS_B, 4'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b0, 32'd0),
            cfg_row(mm_pkg::REG_COLS_B, 4'd1),
            // zero inner dimension: empty dot product
            cfg_row(mm_pkg::REG_INNER_DIM, 4'd0),
            beat_row(mm_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b1, 32'h0000_0000),
            beat_row(mm_pkg::REQ_WRITE_A, 3'd7, 3'd7, 32'h1234_5678, 1'b0, 32'd0),
            beat_row(mm_pkg::REQ_WRITE_B, 3'd7, 3'd7, 32'h8765_4321, 1'b0, 32'd0)
        };

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // dimensions come out of reset at full size
        apb_xfer(1'b0, mm_pkg::REG_ROWS_A, 32'd0, rd);
        if (rd !== {28'd0, mm_pkg::DIM_RESET})
            report_mismatch("rows_a after reset", rd, {28'd0, mm_pkg::DIM_RESET});
        apb_xfer(1'b0, mm_pkg::REG_INNER_DIM, 32'd0, rd);
        if (rd !== {28'd0, mm_pkg::DIM_RESET})
            report_mismatch("inner_dim after reset", rd, {28'd0, mm_pkg::DIM_RESET});
        apb_xfer(1'b0, mm_pkg::REG_COLS_B, 32'd0, rd);
        if (rd !== {28'd0, mm_pkg::DIM_RESET})
            report_mismatch("cols_b after reset", rd, {28'd0, mm_pkg::DIM_RESET});

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_idle(16);
                cfg_write(dir_tab[i].idx, dir_tab[i].dim);
            end
            else
                send_beat(dir_tab[i].req, dir_tab[i].row, dir_tab[i].col,
                          dir_tab[i].value, dir_tab[i].chk, dir_tab[i].want);
        end

        // load every entry of both stores so that any later compute is defined
        for (int i = 0; i < mm_pkg::DEPTH; i++)
        begin
            send_beat(mm_pkg::REQ_WRITE_A, 3'(i / 8), 3'(i % 8), pick_value(), 1'b0, 32'd0);
            send_beat(mm_pkg::REQ_WRITE_B, 3'(i / 8), 3'(i % 8), pick_value(), 1'b0, 32'd0);
        end

        // sessions: new dimensions, a few element updates, one or two computes
        while (n_beats < TOTAL_BEATS)
        begin
            wait_idle(16);
            cfg_write(mm_pkg::REG_ROWS_A, pick_dim());
            cfg_write(mm_pkg::REG_INNER_DIM, pick_dim());
            cfg_write(mm_pkg::REG_COLS_B, pick_dim());
            if ($urandom_range(0, 7) == 0)
                cfg_write(mm_pkg::REG_UNUSED, 4'($urandom));
            nw = $urandom_range(0, 6);
            repeat (nw)
            begin
                r = $urandom_range(0, 9);
                rq = (r < 5) ? mm_pkg::REQ_WRITE_A :
                     (r < 9) ? mm_pkg::REQ_WRITE_B : mm_pkg::REQ_NONE;
                send_beat(rq, 3'($urandom), 3'($urandom), pick_value(), 1'b0, 32'd0);
            end
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
            begin
                if ($urandom_range(0, 4) == 0)
                    wait_idle(0);
                send_beat(mm_pkg::REQ_COMPUTE, 3'($urandom), 3'($urandom), $urandom,
                          1'b0, 32'd0);
            end
        end

        wait_idle(DRAIN_TAIL);

        $display("sent %0d beats including %0d compute requests; %0d C elements checked",
                 n_beats, n_computes, n_elems);
        $display("dimensions swept from zero through saturation, operands at the extremes");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mm_pkg.sv
rtl/core/matrix_multiply_core.sv
tb/tb.sv
